>>> src/nfa_string_acceptor_top_defines.svh
// Assertion macros for the NFA string acceptor.
// Used by the back end and the item queue; needs clk and rst_n in scope.
`ifndef NFA_STRING_ACCEPTOR_TOP_DEFINES_SVH
`define NFA_STRING_ACCEPTOR_TOP_DEFINES_SVH

// Same-cycle implication
`define NFA_SA_CHECK(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define NFA_SA_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/nfa_sa_pkg.sv
// Shared types and codes for the NFA string acceptor.
// No dependencies; imported by every module of the block but nfa_sa_ram.
package nfa_sa_pkg;

    // Largest state and symbol counts the fixed field widths can address
    localparam int MAX_STATES  = 16;
    localparam int MAX_SYMBOLS = 16;

    // Input command codes (tuser)
    typedef enum logic [1:0] {
        K_LOAD  = 2'd0,
        K_SYM   = 2'd1,
        K_EMPTY = 2'd2,
        K_NOP   = 2'd3
    } kind_t;

    // Result verdict codes
    typedef enum logic [1:0] {
        V_PENDING   = 2'd0,
        V_ACCEPT    = 2'd1,
        V_REJECT    = 2'd2,
        V_INCORRECT = 2'd3
    } verdict_t;

    // Configuration register indexes
    localparam logic [1:0] REG_START_STATE   = 2'd0;
    localparam logic [1:0] REG_FINAL_MASK    = 2'd1;
    localparam logic [1:0] REG_STATE_COUNT   = 2'd2;
    localparam logic [1:0] REG_ALPHABET_SIZE = 2'd3;

    // Back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_DRAIN  = 2'd2,
        ST_RESULT = 2'd3
    } back_state_t;

    typedef struct packed {
        logic [3:0]  start_state;
        logic [15:0] final_mask;
        logic [4:0]  state_count;
        logic [4:0]  alphabet_size;
    } cfg_t;

    // Classified item passed from front to back
    typedef struct packed {
        kind_t       kind;
        logic [3:0]  symbol;
        logic [15:0] next_set;
        logic        last;
        logic        load_ok;   // table entry lies inside the table
        logic        sym_bad;   // symbol outside the alphabet
        logic [7:0]  addr;      // table address of a load
    } item_t;

endpackage

>>> src/nfa_sa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module nfa_sa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One access per cycle: write or read
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem_reg[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/nfa_sa_front.sv
// Front end: accepts input items, classifies them and holds one for the queue.
// Depends on nfa_sa_pkg.
module nfa_sa_front
    import nfa_sa_pkg::*;
#(
    parameter int ROWS = 16,
    parameter int COLS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_cmd,
    input  logic [3:0]  in_from,
    input  logic [3:0]  in_symbol,
    input  logic [15:0] in_next_set,
    input  logic        in_last,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    logic        hold_valid_reg, hold_valid_next;
    item_t       hold_reg, hold_next;
    item_t       cls;
    logic [4:0]  sym_limit;
    logic [11:0] addr_wide;

    // Classification
    always_comb
    begin
        sym_limit = (cfg.alphabet_size < 5'(COLS)) ? cfg.alphabet_size : 5'(COLS);
        addr_wide = 12'(in_from) * 12'(COLS) + 12'(in_symbol);
        cls.kind     = kind_t'(in_cmd);
        cls.symbol   = in_symbol;
        cls.next_set = in_next_set;
        cls.last     = in_last;
        cls.load_ok  = (5'(in_from) < 5'(ROWS)) && (5'(in_symbol) < 5'(COLS));
        cls.sym_bad  = (5'(in_symbol) >= sym_limit);
        cls.addr     = addr_wide[7:0];
    end

    // Holding stage
    assign in_ready = !hold_valid_reg || q_ready;
    assign q_valid  = hold_valid_reg;
    assign q_item   = hold_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (q_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (in_valid && in_ready)
        begin
            hold_valid_next = 1'b1;
            hold_next       = cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

>>> src/nfa_sa_queue.sv
// Short item queue between front and back end.
// Depends on nfa_sa_pkg and the assertion macro header.
`include "nfa_string_acceptor_top_defines.svh"

module nfa_sa_queue
    import nfa_sa_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t         mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    `NFA_SA_CHECK_NEXT(a_queue_fill, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

>>> src/nfa_sa_back.sv
// Back end: carries out items against the transition table and holds the result.
// Depends on nfa_sa_pkg, nfa_sa_ram and the assertion macro header.
`include "nfa_string_acceptor_top_defines.svh"

module nfa_sa_back
    import nfa_sa_pkg::*;
#(
    parameter int ROWS = 16,
    parameter int COLS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        q_valid,
    output logic        q_ready,
    input  item_t       q_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_active,
    output logic [1:0]  out_verdict
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = $clog2(ROWS);

    back_state_t     state_reg, state_next;
    item_t           item_reg, item_next;
    logic [ROWS-1:0] active_reg, active_next;
    logic            in_string_reg, in_string_next;
    logic            bad_reg, bad_next;
    logic [ROWS-1:0] acc_reg, acc_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [AW-1:0]   scan_addr_reg, scan_addr_next;
    logic            rd_hit_reg, rd_hit_next;
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic            out_valid_reg, out_valid_next;
    logic [15:0]     out_active_reg, out_active_next;
    verdict_t        out_verdict_reg, out_verdict_next;

    logic            ram_en, ram_we;
    logic [AW-1:0]   ram_addr;
    logic [ROWS-1:0] ram_wdata, ram_rdata;

    logic [4:0]      n_use;
    logic [ROWS-1:0] mask_n, start_set, base_set, row_data;
    logic            bad_eff, issue, judge_hit, out_free;
    verdict_t        verdict;

    // Transition table
    nfa_sa_ram #(
        .WIDTH (ROWS),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // States in use, start set and acceptance test
    always_comb
    begin
        n_use = (cfg.state_count < 5'(ROWS)) ? cfg.state_count : 5'(ROWS);
        for (int i = 0; i < ROWS; i++)
        begin
            mask_n[i]    = (5'(i) < n_use);
            start_set[i] = (cfg.start_state == 4'(i)) && mask_n[i];
        end
        base_set  = in_string_reg ? active_reg : start_set;
        bad_eff   = in_string_reg && bad_reg;
        judge_hit = |(active_reg & cfg.final_mask[ROWS-1:0] & mask_n);
        row_data  = rd_hit_reg ? ram_rdata : '0;
        issue     = active_reg[q_reg] && (5'(q_reg) < n_use);
        out_free  = !out_valid_reg || out_ready;
    end

    // Verdict of the item being finished
    always_comb
    begin
        unique case (item_reg.kind)
            K_SYM:
            begin
                if (!item_reg.last)
                begin
                    verdict = V_PENDING;
                end
                else if (bad_reg)
                begin
                    verdict = V_INCORRECT;
                end
                else
                begin
                    verdict = judge_hit ? V_ACCEPT : V_REJECT;
                end
            end
            K_EMPTY: verdict = judge_hit ? V_ACCEPT : V_REJECT;
            K_LOAD:  verdict = V_PENDING;
            K_NOP:   verdict = V_PENDING;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        active_next      = active_reg;
        in_string_next   = in_string_reg;
        bad_next         = bad_reg;
        acc_next         = acc_reg;
        q_next           = q_reg;
        scan_addr_next   = scan_addr_reg;
        rd_hit_next      = 1'b0;
        vld_next         = vld_reg;
        out_valid_next   = out_valid_reg;
        out_active_next  = out_active_reg;
        out_verdict_next = out_verdict_reg;
        q_ready          = 1'b0;
        ram_en           = 1'b0;
        ram_we           = 1'b0;
        ram_addr         = scan_addr_reg;
        ram_wdata        = q_item.next_set[ROWS-1:0];

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    item_next  = q_item;
                    state_next = ST_RESULT;
                    unique case (q_item.kind)
                        K_LOAD:
                        begin
                            if (q_item.load_ok)
                            begin
                                ram_en   = 1'b1;
                                ram_we   = 1'b1;
                                ram_addr = q_item.addr[AW-1:0];
                                vld_next[q_item.addr[AW-1:0]] = 1'b1;
                            end
                        end
                        K_SYM:
                        begin
                            in_string_next = 1'b1;
                            active_next    = base_set;
                            if (q_item.sym_bad || bad_eff)
                            begin
                                bad_next = 1'b1;
                            end
                            else
                            begin
                                bad_next       = 1'b0;
                                acc_next       = '0;
                                q_next         = '0;
                                scan_addr_next = AW'(q_item.symbol);
                                state_next     = ST_SCAN;
                            end
                        end
                        K_EMPTY:
                        begin
                            in_string_next = 1'b0;
                            bad_next       = 1'b0;
                            active_next    = start_set;
                        end
                        K_NOP:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end

            // One table row per state; the RAM registers its read data
            ST_SCAN:
            begin
                ram_en         = issue;
                rd_hit_next    = issue && vld_reg[scan_addr_reg];
                acc_next       = acc_reg | row_data;
                q_next         = q_reg + 1'b1;
                scan_addr_next = scan_addr_reg + AW'(COLS);
                if (q_reg == QW'(ROWS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end

            ST_DRAIN:
            begin
                active_next = (acc_reg | row_data) & mask_n;
                state_next  = ST_RESULT;
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_active_next  = 16'(active_reg);
                    out_verdict_next = verdict;
                    state_next       = ST_IDLE;
                    if (item_reg.kind == K_SYM && item_reg.last)
                    begin
                        in_string_next = 1'b0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= '0;
            in_string_reg <= 1'b0;
            bad_reg       <= 1'b0;
            rd_hit_reg    <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            in_string_reg <= in_string_next;
            bad_reg       <= bad_next;
            rd_hit_reg    <= rd_hit_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg        <= item_next;
        acc_reg         <= acc_next;
        q_reg           <= q_next;
        scan_addr_reg   <= scan_addr_next;
        out_active_reg  <= out_active_next;
        out_verdict_reg <= out_verdict_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_active  = out_active_reg;
    assign out_verdict = out_verdict_reg;

    `NFA_SA_CHECK(a_drain_after_scan, state_reg == ST_DRAIN, $past(state_reg) == ST_SCAN, "drain entered without a scan")
    `NFA_SA_CHECK(a_scan_clean_symbol, state_reg == ST_SCAN, item_reg.kind == K_SYM && !bad_reg, "scan on a non-symbol or bad string")
    `NFA_SA_CHECK_NEXT(a_result_delivered, state_reg == ST_RESULT && out_free, out_valid_reg, "finished item not presented")

endmodule

>>> src/nfa_string_acceptor_top.sv
// NFA string acceptor top level: configuration registers, front end, queue, back end.
// Depends on nfa_sa_pkg, nfa_sa_front, nfa_sa_queue, nfa_sa_back.
//
// Usage: load transition entries (tuser 0), then feed string symbols (tuser 1)
// with tlast on the final symbol, or an empty-string item (tuser 2). Every item
// yields exactly one result item carrying the active state set and a verdict
// (pending, accepted, rejected, incorrect string).
// Configuration is written through cfg_wr_en/cfg_index/cfg_data while idle.
// Loads, empty strings and unknown commands pass through the back end's idle and
// result states; a symbol of a clean string also runs the one-row-per-cycle scan
// of the single-port transition table and a drain state. The back end finishes one
// item before it takes the next; items reach it via the front register and queue.
// Reset clears the table valid bits (all entries read as empty), the active
// set, the string flags and the registers (start 0, final mask 0, 16 states,
// 16 symbols). A stalled receiver holds the result; the front register and a
// two-entry queue keep accepting items until they fill.
module nfa_string_acceptor_top
    import nfa_sa_pkg::*;
#(
    parameter int STATE_COUNT  = 16,
    parameter int SYMBOL_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // from_state[3:0], symbol[7:4], next_set[23:8]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // active_states[15:0], verdict[17:16], zero[23:18]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ROWS = (STATE_COUNT < MAX_STATES) ? STATE_COUNT : MAX_STATES;
    localparam int COLS = (SYMBOL_COUNT < MAX_SYMBOLS) ? SYMBOL_COUNT : MAX_SYMBOLS;

    cfg_t        cfg_reg;
    logic        fq_valid, fq_ready, qb_valid, qb_ready;
    item_t       fq_item, qb_item;
    logic [15:0] out_active;
    logic [1:0]  out_verdict;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_state   <= '0;
            cfg_reg.final_mask    <= '0;
            cfg_reg.state_count   <= 5'd16;
            cfg_reg.alphabet_size <= 5'd16;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_START_STATE:   cfg_reg.start_state   <= cfg_data[3:0];
                REG_FINAL_MASK:    cfg_reg.final_mask    <= cfg_data;
                REG_STATE_COUNT:   cfg_reg.state_count   <= cfg_data[4:0];
                REG_ALPHABET_SIZE: cfg_reg.alphabet_size <= cfg_data[4:0];
            endcase
        end
    end

    nfa_sa_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (s_tuser),
        .in_from     (s_tdata[3:0]),
        .in_symbol   (s_tdata[7:4]),
        .in_next_set (s_tdata[23:8]),
        .in_last     (s_tlast),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_item      (fq_item)
    );

    nfa_sa_queue #(
        .DEPTH (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    nfa_sa_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_item      (qb_item),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_active  (out_active),
        .out_verdict (out_verdict)
    );

    assign m_tdata = {6'b0, out_verdict, out_active};

endmodule

>>> verif/nfa_string_acceptor_top_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for nfa_string_acceptor_top: directed table, then random phases.
// Depends on nfa_sa_pkg and the block's RTL; every result is predicted in-line.
module nfa_string_acceptor_top_tb;
    import nfa_sa_pkg::*;

    localparam int DRAIN_CYCLES = 30;
    localparam int PHASE_ITEMS  = 155;
    localparam int PHASE_COUNT  = 6;
    localparam int MAX_PRINTS   = 40;

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic [15:0] next_set;
        logic [3:0]  symbol;
        logic [3:0]  from_state;
    } in_word_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [5:0]  pad;
        verdict_t    verdict;
        logic [15:0] active;
    } out_word_t;

    typedef struct packed {
        logic [15:0] active;
        verdict_t    verdict;
    } nfa_result_t;

    // One directed row: either a register write or an item
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  reg_idx;
        logic [15:0] reg_val;
        kind_t       kind;
        logic [3:0]  from_state;
        logic [3:0]  symbol;
        logic [15:0] next_set;
        logic        last_sym;
        logic        pinned;      // expected result typed in below
        logic [15:0] pin_active;
        verdict_t    pin_verdict;
    } stim_row_t;

    // DUT signals
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Typed-in expectation travels with the item
    logic        pin_valid  = 1'b0;
    logic [15:0] pin_active = '0;
    verdict_t    pin_verdict = V_PENDING;

    // Predictor state
    logic [15:0] trans_tbl [16][16];
    logic [15:0] active_set;
    logic        in_string;
    logic        bad_seen;
    logic [3:0]  start_reg;
    logic [15:0] fin_mask;
    logic [4:0]  count_reg;
    logic [4:0]  alpha_reg;

    nfa_result_t predicted_results [$];

    int send_idle = 0;
    int recv_idle = 0;
    int error_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int accepted_cnt = 0;
    int rejected_cnt = 0;
    int incorrect_cnt = 0;

    nfa_string_acceptor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Directed table
    // cfg idx                value     kind     from   sym    next      last  pin   active    verdict
    stim_row_t directed_rows [27] = '{
        // fresh after reset: empty table, final mask zero
        '{1'b0, REG_START_STATE, 16'h0000, K_SYM,   4'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 16'h0000, V_REJECT},
        '{1'b0, REG_START_STATE, 16'h0000, K_EMPTY, 4'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 16'h0001, V_REJECT},
        '{1'b0, REG_START_STATE, 16'h0000, K_NOP,   4'd15, 4'd15, 16'hFFFF, 1'b1, 1'b1, 16'h0001, V_PENDING},
        // table corners
        '{1'b0, REG_START_STATE, 16'h0000, K_LOAD,  4'd0,  4'd0,  16'hFFFF, 1'b0, 1'b1, 16'h0001, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_LOAD,  4'd15, 4'd15, 16'h8000, 1'b1, 1'b1, 16'h0001, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_LOAD,  4'd0,  4'd15, 16'h8000, 1'b0, 1'b1, 16'h0001, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_LOAD,  4'd15, 4'd0,  16'h0001, 1'b0, 1'b1, 16'h0001, V_PENDING},
        // string with a load in the middle
        '{1'b0, REG_START_STATE, 16'h0000, K_SYM,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_SYM,   4'd9,  4'd15, 16'h1234, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_LOAD,  4'd7,  4'd3,  16'h5A5A, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_SYM,   4'd0,  4'd0,  16'h0000, 1'b1, 1'b0, 16'h0000, V_PENDING},
        // symbol outside a one-symbol alphabet
        '{1'b1, REG_FINAL_MASK,  16'hFFFF, K_NOP,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b1, REG_ALPHABET_SIZE, 16'd1,  K_NOP,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_SYM,   4'd0,  4'd5,  16'h0000, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_SYM,   4'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 16'h0001, V_INCORRECT},
        '{1'b0, REG_START_STATE, 16'h0000, K_EMPTY, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 16'h0001, V_ACCEPT},
        // no states in use
        '{1'b1, REG_STATE_COUNT, 16'd0,    K_NOP,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_EMPTY, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 16'h0000, V_REJECT},
        '{1'b0, REG_START_STATE, 16'h0000, K_SYM,   4'd0,  4'd0,  16'h0000, 1'b1, 1'b1, 16'h0000, V_REJECT},
        // counts above the table size clamp to it; start at the top state
        '{1'b1, REG_STATE_COUNT, 16'd31,   K_NOP,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b1, REG_ALPHABET_SIZE, 16'd31, K_NOP,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b1, REG_START_STATE, 16'd15,   K_NOP,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_SYM,   4'd0,  4'd15, 16'h0000, 1'b1, 1'b0, 16'h0000, V_PENDING},
        // start state outside the states in use; successors masked to four states
        '{1'b1, REG_STATE_COUNT, 16'd4,    K_NOP,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_EMPTY, 4'd0,  4'd0,  16'h0000, 1'b0, 1'b1, 16'h0000, V_REJECT},
        '{1'b1, REG_START_STATE, 16'd0,    K_NOP,   4'd0,  4'd0,  16'h0000, 1'b0, 1'b0, 16'h0000, V_PENDING},
        '{1'b0, REG_START_STATE, 16'h0000, K_SYM,   4'd0,  4'd0,  16'h0000, 1'b1, 1'b0, 16'h0000, V_PENDING}
    };

    // Clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver backpressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    function automatic int states_in_use();
        return (int'(count_reg) < 16) ? int'(count_reg) : 16;
    endfunction

    function automatic int symbols_in_use();
        return (int'(alpha_reg) < 16) ? int'(alpha_reg) : 16;
    endfunction

    function automatic logic [15:0] low_mask(input int n);
        return (n >= 16) ? 16'hFFFF : 16'((32'd1 << n) - 1);
    endfunction

    function automatic logic [15:0] start_set();
        return (int'(start_reg) < states_in_use()) ? (16'd1 << start_reg) : 16'h0000;
    endfunction

    function automatic verdict_t judge_set(input logic [15:0] set);
        return |(set & fin_mask & low_mask(states_in_use())) ? V_ACCEPT : V_REJECT;
    endfunction

    // Step the automaton by one item and return the result it should report
    function automatic nfa_result_t advance_nfa(input kind_t kind, input logic [3:0] from_st,
                                                input logic [3:0] sym, input logic [15:0] nxt,
                                                input logic last_sym);
        nfa_result_t res;
        logic [15:0] acc;
        int n;
        n = states_in_use();
        res.verdict = V_PENDING;
        case (kind)
            K_LOAD:
            begin
                trans_tbl[from_st][sym] = nxt;
            end
            K_SYM:
            begin
                if (!in_string)
                begin
                    active_set = start_set();
                    bad_seen = 1'b0;
                    in_string = 1'b1;
                end
                if (int'(sym) >= symbols_in_use())
                    bad_seen = 1'b1;
                else if (!bad_seen)
                begin
                    acc = '0;
                    for (int q = 0; q < n; q++)
                        if (active_set[q])
                            acc |= trans_tbl[q][sym];
                    active_set = acc & low_mask(n);
                end
                if (last_sym)
                begin
                    res.verdict = bad_seen ? V_INCORRECT : judge_set(active_set);
                    in_string = 1'b0;
                end
            end
            K_EMPTY:
            begin
                in_string = 1'b0;
                bad_seen = 1'b0;
                active_set = start_set();
                res.verdict = judge_set(active_set);
            end
            default: ;
        endcase
        res.active = active_set;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("%0t: result %0d %s: got %0h, expected %0h",
                     $time, results_seen, what, got, want);
    endtask

    // Predict on accepted items, check accepted results
    always @(posedge clk)
    begin : check_results
        nfa_result_t pred;
        out_word_t   got;
        in_word_t    word;
        if (s_tvalid && s_tready)
        begin
            word = s_tdata;
            pred = advance_nfa(kind_t'(s_tuser), word.from_state, word.symbol,
                               word.next_set, s_tlast);
            if (pin_valid)
                pred = '{pin_active, pin_verdict};
            predicted_results.insert(predicted_results.size(), pred);
            items_sent++;
            case (pred.verdict)
                V_ACCEPT:    accepted_cnt++;
                V_REJECT:    rejected_cnt++;
                V_INCORRECT: incorrect_cnt++;
                default: ;
            endcase
        end
        if (m_tvalid && m_tready)
        begin
            got = m_tdata;
            results_seen++;
            if (predicted_results.size() == 0)
                report_mismatch("unexpected result, active set", got.active, 16'h0);
            else
            begin
                pred = predicted_results.pop_front();
                if (got.active !== pred.active)
                    report_mismatch("active set", got.active, pred.active);
                if (got.verdict !== pred.verdict)
                    report_mismatch("verdict", 16'(got.verdict), 16'(pred.verdict));
            end
        end
    end

    // Present one item and hold it until accepted
    task automatic push_item(input kind_t kind, input logic [3:0] from_st, input logic [3:0] sym,
                             input logic [15:0] nxt, input logic last_sym, input logic pinned,
                             input logic [15:0] pa, input verdict_t pv);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= in_word_t'{nxt, sym, from_st};
        s_tuser     <= kind;
        s_tlast     <= last_sym;
        pin_valid   <= pinned;
        pin_active  <= pa;
        pin_verdict <= pv;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop sending and wait for the block to drain
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_START_STATE:   start_reg = val[3:0];
            REG_FINAL_MASK:    fin_mask  = val;
            REG_STATE_COUNT:   count_reg = val[4:0];
            REG_ALPHABET_SIZE: alpha_reg = val[4:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Successor masks: single bits, pairs, dense and the extremes
    function automatic logic [15:0] rand_mask();
        case ($urandom_range(3))
            0: return 16'd1 << $urandom_range(15);
            1: return (16'd1 << $urandom_range(15)) | (16'd1 << $urandom_range(15));
            2: return 16'($urandom);
            default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        endcase
    endfunction

    // Mostly states and symbols in use, now and then any index
    function automatic logic [3:0] pick_state();
        int n;
        n = states_in_use();
        if (n == 0 || $urandom_range(15) == 0)
            return 4'($urandom_range(15));
        return 4'($urandom_range(n - 1));
    endfunction

    function automatic logic [3:0] pick_symbol();
        int m;
        m = symbols_in_use();
        if (m == 0 || $urandom_range(15) == 0)
            return 4'($urandom_range(15));
        return 4'($urandom_range(m - 1));
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(11))
            0: return 16'd1;
            1: return 16'd16;
            2: return 16'($urandom_range(17, 31));
            3: return 16'd0;
            default: return 16'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic configure_phase();
        settle();
        write_reg(REG_START_STATE, 16'($urandom_range(15)));
        write_reg(REG_FINAL_MASK, rand_mask());
        write_reg(REG_STATE_COUNT, pick_count());
        write_reg(REG_ALPHABET_SIZE, pick_count());
    endtask

    // Fill the table, then mostly strings with loads, empties and noise mixed in
    task automatic run_phase(input int items);
        int sent;
        int len;
        int r;
        sent = 0;
        repeat (20)
        begin
            push_item(K_LOAD, pick_state(), pick_symbol(), rand_mask(), 1'($urandom_range(1)),
                      1'b0, '0, V_PENDING);
            sent++;
        end
        while (sent < items)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                push_item(K_LOAD, pick_state(), pick_symbol(), rand_mask(),
                          1'($urandom_range(1)), 1'b0, '0, V_PENDING);
                sent++;
            end
            else if (r < 20)
            begin
                push_item(K_EMPTY, 4'($urandom), 4'($urandom), 16'($urandom),
                          1'($urandom_range(1)), 1'b0, '0, V_PENDING);
                sent++;
            end
            else if (r < 23)
            begin
                push_item(K_NOP, 4'($urandom), 4'($urandom), 16'($urandom),
                          1'($urandom_range(1)), 1'b0, '0, V_PENDING);
                sent++;
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                begin
                    // occasional load inside a string, or a string cut short
                    if (k > 0 && $urandom_range(19) == 0)
                    begin
                        push_item(K_LOAD, pick_state(), pick_symbol(), rand_mask(), 1'b0,
                                  1'b0, '0, V_PENDING);
                        sent++;
                    end
                    if (k > 0 && $urandom_range(24) == 0)
                    begin
                        push_item(K_EMPTY, '0, '0, '0, 1'b0, 1'b0, '0, V_PENDING);
                        sent++;
                        break;
                    end
                    push_item(K_SYM, 4'($urandom), pick_symbol(), 16'($urandom), k == len - 1,
                              1'b0, '0, V_PENDING);
                    sent++;
                end
            end
        end
    endtask

    // Main sequence
    initial
    begin
        stim_row_t row;
        for (int i = 0; i < 16; i++)
            for (int j = 0; j < 16; j++)
                trans_tbl[i][j] = '0;
        active_set = '0;
        in_string  = 1'b0;
        bad_seen   = 1'b0;
        start_reg  = 4'd0;
        fin_mask   = 16'h0000;
        count_reg  = 5'd16;
        alpha_reg  = 5'd16;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 17;
        recv_idle = 59;
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_cfg)
            begin
                settle();
                write_reg(row.reg_idx, row.reg_val);
            end
            else
                push_item(row.kind, row.from_state, row.symbol, row.next_set, row.last_sym,
                          row.pinned, row.pin_active, row.pin_verdict);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            send_idle = (p < 2) ? 17 : (p < 4) ? 59 : 0;
            recv_idle = (p < 2) ? 59 : (p < 4) ? 17 : 0;
            configure_phase();
            run_phase(PHASE_ITEMS);
        end
        settle();

        $display("Checked %0d results for %0d items over %0d register settings,",
                 results_seen, items_sent, PHASE_COUNT + 1);
        $display("with %0d strings accepted, %0d rejected and %0d judged incorrect.",
                 accepted_cnt, rejected_cnt, incorrect_cnt);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Timeout with %0d results outstanding", predicted_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
